/* hdl/ifs_pkg.sv */
package ifs_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ  = 2'd0,
        REQ_DEQ  = 2'd1,
        REQ_SRCH = 2'd2
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic clear;
        logic scan;
    } cell_ctrl_t;

endpackage

/* hdl/ifs_cell.sv */
module ifs_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                             clk,
    input  ifs_pkg::cell_ctrl_t              ctrl,
    input  logic [CNT_W-1:0]                 count,
    input  logic signed [ifs_pkg::DATA_W-1:0] value,
    input  logic signed [ifs_pkg::DATA_W-1:0] right_data,
    input  logic                             right_hit,
    output logic signed [ifs_pkg::DATA_W-1:0] data,
    output logic                             hit
);

    logic signed [ifs_pkg::DATA_W-1:0] data_reg;
    logic signed [ifs_pkg::DATA_W-1:0] data_next;
    logic                              hit_reg;
    logic                              hit_next;
    logic                              occupied;

    assign occupied = count > CNT_W'(INDEX);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load && (count == CNT_W'(INDEX)))
        begin
            data_next = value;
        end
        else if (ctrl.shift)
        begin
            data_next = right_data;
        end
    end

    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.clear)
        begin
            hit_next = 1'b0;
        end
        else if (ctrl.scan)
        begin
            hit_next = right_hit || (occupied && (data_reg == value));
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        hit_reg  <= hit_next;
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

/* hdl/integer_fifo_with_search.sv */
// Bounded FIFO of signed 32-bit integers with a membership search, built as a
// row of DEPTH cells where cell 0 always holds the head. One request is taken
// at a time. An enqueue or dequeue item goes from the idle state to the exec
// state, where its result is registered, and the block then returns to idle
// for the next item. A search first passes through the scan state, where the
// hit bit ripples one cell per cycle from the tail end of the row to the head,
// and then registers its result in the exec state. A stalled result holds the
// following item in the exec state until the output register frees. A new
// request is accepted whenever the block is idle, even while the previous
// result still waits at the output register. Enqueue on a full queue is
// dropped with status full, dequeue on an empty queue returns status empty;
// request code 3 is a no-op that only reports the current state.
module integer_fifo_with_search #(
    parameter int DEPTH = ifs_pkg::DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [ifs_pkg::REQ_W-1:0]           req_type,
    input  logic signed [ifs_pkg::DATA_W-1:0]   value,
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic [ifs_pkg::STATUS_W-1:0]        status,
    output logic signed [ifs_pkg::DATA_W-1:0]   removed_value,
    output logic                                found,
    output logic signed [ifs_pkg::DATA_W-1:0]   front_value,
    output logic                                is_empty,
    output logic [CNT_W-1:0]                    occupancy
);

    localparam int SCAN_W = $clog2(DEPTH);

    ifs_pkg::state_t                    state_reg;
    ifs_pkg::state_t                    state_next;
    logic [SCAN_W-1:0]                  scan_reg;
    logic [SCAN_W-1:0]                  scan_next;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic [ifs_pkg::REQ_W-1:0]          op_reg;
    logic signed [ifs_pkg::DATA_W-1:0]  key_reg;
    logic                               res_valid_reg;
    logic                               res_valid_next;

    logic [ifs_pkg::STATUS_W-1:0]       status_reg;
    logic signed [ifs_pkg::DATA_W-1:0]  removed_reg;
    logic                               found_reg;
    logic signed [ifs_pkg::DATA_W-1:0]  front_reg;
    logic                               empty_reg;
    logic [CNT_W-1:0]                   occ_reg;

    logic                               accept;
    logic                               do_op;
    logic                               scan_last;
    logic                               is_full;
    logic                               is_void;
    ifs_pkg::cell_ctrl_t                ctrl;

    logic signed [ifs_pkg::DATA_W-1:0]  data_w [DEPTH+1];
    logic                               hit_w  [DEPTH+1];

    logic [ifs_pkg::STATUS_W-1:0]       st_c;
    logic signed [ifs_pkg::DATA_W-1:0]  rem_c;
    logic                               fnd_c;
    logic signed [ifs_pkg::DATA_W-1:0]  front_c;

    assign is_full   = count_reg == CNT_W'(DEPTH);
    assign is_void   = count_reg == '0;
    assign scan_last = scan_reg == SCAN_W'(DEPTH - 1);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ifs_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req_type == ifs_pkg::REQ_SRCH) ? ifs_pkg::S_SCAN
                                                                 : ifs_pkg::S_EXEC;
                end
            end
            ifs_pkg::S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ifs_pkg::S_EXEC;
                end
            end
            ifs_pkg::S_EXEC:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    state_next = ifs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ifs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall  = 1'b1;
        do_op      = 1'b0;
        ctrl       = '0;
        scan_next  = scan_reg;
        unique case (state_reg)
            ifs_pkg::S_IDLE:
            begin
                req_stall  = 1'b0;
                ctrl.clear = 1'b1;
                scan_next  = '0;
            end
            ifs_pkg::S_SCAN:
            begin
                ctrl.scan = 1'b1;
                scan_next = scan_reg + SCAN_W'(1);
            end
            ifs_pkg::S_EXEC:
            begin
                do_op = !res_valid_reg || !res_stall;
                ctrl.load  = do_op && (op_reg == ifs_pkg::REQ_ENQ) && !is_full;
                ctrl.shift = do_op && (op_reg == ifs_pkg::REQ_DEQ) && !is_void;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        st_c       = ifs_pkg::ST_OK;
        rem_c      = '0;
        fnd_c      = 1'b0;
        count_next = count_reg;
        front_c    = is_void ? '0 : data_w[0];
        priority if (op_reg == ifs_pkg::REQ_ENQ)
        begin
            if (is_full)
            begin
                st_c = ifs_pkg::ST_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                front_c    = is_void ? key_reg : data_w[0];
            end
        end
        else if (op_reg == ifs_pkg::REQ_DEQ)
        begin
            if (is_void)
            begin
                st_c = ifs_pkg::ST_EMPTY;
            end
            else
            begin
                rem_c      = data_w[0];
                count_next = count_reg - CNT_W'(1);
                front_c    = (count_reg == CNT_W'(1)) ? '0 : data_w[1];
            end
        end
        else if (op_reg == ifs_pkg::REQ_SRCH)
        begin
            fnd_c = hit_w[0];
        end
        else
        begin
            st_c = ifs_pkg::ST_OK;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (do_op)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ifs_pkg::S_IDLE;
            scan_reg      <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            res_valid_reg <= res_valid_next;
            if (do_op)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req_type;
            key_reg <= value;
        end
        if (do_op)
        begin
            status_reg  <= st_c;
            removed_reg <= rem_c;
            found_reg   <= fnd_c;
            front_reg   <= front_c;
            empty_reg   <= count_next == '0;
            occ_reg     <= count_next;
        end
    end

    assign data_w[DEPTH] = '0;
    assign hit_w[DEPTH]  = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        ifs_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .value      (key_reg),
            .right_data (data_w[i+1]),
            .right_hit  (hit_w[i+1]),
            .data       (data_w[i]),
            .hit        (hit_w[i])
        );
    end

    assign res_valid     = res_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign found         = found_reg;
    assign front_value   = front_reg;
    assign is_empty      = empty_reg;
    assign occupancy     = occ_reg;

endmodule

/* tb/tb_integer_fifo_with_search.sv */
`timescale 1ns / 1ps

module tb_integer_fifo_with_search;

    localparam int DEPTH = ifs_pkg::DEPTH_DEF;
    localparam int STUCK_LIMIT = 500;
    localparam int RANDOM_ITEMS = 1900;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [ifs_pkg::REQ_W-1:0] REQ_NOP = 2'd3;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED,
        MIX_SEARCH
    } mix_t;

    typedef struct {
        ifs_pkg::status_t                   status;
        logic signed [ifs_pkg::DATA_W-1:0]  removed;
        logic                               hit;
        logic signed [ifs_pkg::DATA_W-1:0]  front;
        logic                               empty;
        logic [4:0]                         occ;
    } outcome_t;

    class fifo_scoreboard;
        logic signed [ifs_pkg::DATA_W-1:0] store [DEPTH];
        int head;
        int tail;
        int count;
        int errors;
        outcome_t pending [$];

        function new();
            head = 0;
            tail = 0;
            count = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("ERROR %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_request(logic [ifs_pkg::REQ_W-1:0] req,
                                   logic signed [ifs_pkg::DATA_W-1:0] val);
            outcome_t o;
            o.status = ifs_pkg::ST_OK;
            o.removed = '0;
            o.hit = 1'b0;
            o.front = '0;
            case (req)
                ifs_pkg::REQ_ENQ:
                begin
                    if (count >= DEPTH)
                        o.status = ifs_pkg::ST_FULL;
                    else
                    begin
                        store[tail] = val;
                        tail = (tail + 1) % DEPTH;
                        count++;
                    end
                end
                ifs_pkg::REQ_DEQ:
                begin
                    if (count == 0)
                        o.status = ifs_pkg::ST_EMPTY;
                    else
                    begin
                        o.removed = store[head];
                        head = (head + 1) % DEPTH;
                        count--;
                    end
                end
                ifs_pkg::REQ_SRCH:
                begin
                    for (int i = 0; i < count; i++)
                        if (store[(head + i) % DEPTH] == val)
                            o.hit = 1'b1;
                end
                default:
                begin
                end
            endcase
            if (count != 0)
                o.front = store[head];
            o.empty = (count == 0);
            o.occ = count[4:0];
            pending.push_back(o);
        endfunction

        function logic signed [ifs_pkg::DATA_W-1:0] stored_key();
            if (count > 0 && $urandom_range(0, 1) == 1)
                return store[(head + $urandom_range(0, count - 1)) % DEPTH];
            return $urandom();
        endfunction

        task check_result(logic [ifs_pkg::STATUS_W-1:0] st,
                          logic signed [ifs_pkg::DATA_W-1:0] rem,
                          logic hit, logic signed [ifs_pkg::DATA_W-1:0] front,
                          logic empty, logic [4:0] occ);
            outcome_t o;
            if (pending.size() == 0)
            begin
                report("result item with no request pending");
                return;
            end
            o = pending.pop_front();
            if (st !== o.status)
                report($sformatf("status got %0d expected %0d", st, o.status));
            if (rem !== o.removed)
                report($sformatf("removed_value got %0d expected %0d", rem, o.removed));
            if (hit !== o.hit)
                report($sformatf("found got %0b expected %0b", hit, o.hit));
            if (front !== o.front)
                report($sformatf("front_value got %0d expected %0d", front, o.front));
            if (empty !== o.empty)
                report($sformatf("is_empty got %0b expected %0b", empty, o.empty));
            if (occ !== o.occ)
                report($sformatf("occupancy got %0d expected %0d", occ, o.occ));
        endtask
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               req_valid = 1'b0;
    logic                               req_stall;
    logic [ifs_pkg::REQ_W-1:0]          req_type = '0;
    logic signed [ifs_pkg::DATA_W-1:0]  value = '0;
    logic                               res_valid;
    logic                               res_stall = 1'b0;
    logic [ifs_pkg::STATUS_W-1:0]       status;
    logic signed [ifs_pkg::DATA_W-1:0]  removed_value;
    logic                               found;
    logic signed [ifs_pkg::DATA_W-1:0]  front_value;
    logic                               is_empty;
    logic [4:0]                         occupancy;

    fifo_scoreboard sb = new();
    int idle_max = 10;
    int stuck = 0;

    integer_fifo_with_search dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .value         (value),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .status        (status),
        .removed_value (removed_value),
        .found         (found),
        .front_value   (front_value),
        .is_empty      (is_empty),
        .occupancy     (occupancy)
    );

    always #5 clk = ~clk;

    function automatic logic signed [ifs_pkg::DATA_W-1:0] draw_value();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return -32'sd1;
                default: return '0;
            endcase
        end
        if (r < 3)
            return $urandom_range(0, 7);
        return $urandom();
    endfunction

    function automatic logic [ifs_pkg::REQ_W-1:0] draw_req(mix_t mix);
        int r;
        int enq_lim;
        int deq_lim;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:     begin enq_lim = 78; deq_lim = 88; end
            MIX_DRAIN:    begin enq_lim = 20; deq_lim = 78; end
            MIX_BALANCED: begin enq_lim = 43; deq_lim = 75; end
            default:      begin enq_lim = 25; deq_lim = 45; end
        endcase
        if (r < 3)
            return REQ_NOP;
        if (r < enq_lim)
            return ifs_pkg::REQ_ENQ;
        if (r < deq_lim)
            return ifs_pkg::REQ_DEQ;
        return ifs_pkg::REQ_SRCH;
    endfunction

    task automatic send_item(logic [ifs_pkg::REQ_W-1:0] req,
                             logic signed [ifs_pkg::DATA_W-1:0] val);
        int gap;
        gap = (idle_max > 0) ? $urandom_range(0, idle_max) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type <= req;
        value <= val;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        sb.note_request(req, val);
    endtask

    task automatic send_random(mix_t mix);
        logic [ifs_pkg::REQ_W-1:0] req;
        req = draw_req(mix);
        if (req == ifs_pkg::REQ_SRCH)
            send_item(req, sb.stored_key());
        else
            send_item(req, draw_value());
    endtask

    task automatic hold_until_drained();
        req_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int n;
        wait (rst_n);
        forever
        begin
            n = (idle_max > 0) ? $urandom_range(0, idle_max) : 0;
            if (n > 0)
            begin
                res_stall <= 1'b1;
                repeat (n) @(posedge clk);
                res_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(res_valid && !res_stall));
            sb.check_result(status, removed_value, found, front_value, is_empty, occupancy);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall))
            stuck <= 0;
        else
        begin
            stuck <= stuck + 1;
            if (stuck == STUCK_LIMIT)
            begin
                $display("tb_integer_fifo_with_search NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int sent;
        int len;
        bit paused;
        mix_t mix;
        sent = 0;
        paused = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue corners, extremes, hit and miss
        send_item(ifs_pkg::REQ_DEQ, $urandom());
        send_item(ifs_pkg::REQ_SRCH, $urandom());
        send_item(REQ_NOP, $urandom());
        send_item(ifs_pkg::REQ_ENQ, 32'sh8000_0000);
        send_item(ifs_pkg::REQ_ENQ, 32'sh7fff_ffff);
        send_item(ifs_pkg::REQ_SRCH, 32'sh7fff_ffff);
        send_item(ifs_pkg::REQ_SRCH, 32'sd5);
        send_item(ifs_pkg::REQ_DEQ, $urandom());
        // fill to full, then overflow
        for (int i = 0; i < DEPTH - 1; i++)
            send_item(ifs_pkg::REQ_ENQ, $urandom());
        send_item(ifs_pkg::REQ_ENQ, -32'sd1);
        send_item(ifs_pkg::REQ_DEQ, $urandom());

        while (sent < RANDOM_ITEMS)
        begin
            mix = mix_t'($urandom_range(0, 3));
            idle_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            len = $urandom_range(20, 120);
            for (int i = 0; i < len; i++)
            begin
                send_random(mix);
                sent++;
            end
            if (!paused && sent >= RANDOM_ITEMS / 2)
            begin
                hold_until_drained();
                paused = 1'b1;
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_integer_fifo_with_search OK");
        else
            $display("tb_integer_fifo_with_search NOT OK");
        $finish;
    end

endmodule
